FILE: hdl/lfca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfca_pkg;

    localparam int ID_W      = 16;
    localparam int IN_TIME_W = 32;
    localparam int CHAIR_W   = 6;

    typedef struct packed {
        logic rel_en;
        logic alloc_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/lfca_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lfca_cell #(
    parameter int TIME_BITS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lfca_pkg::t_cell_ctl    i_ctl,
    input  wire  [TIME_BITS-1:0]   i_now,
    input  wire  [TIME_BITS-1:0]   i_leave,
    input  wire                    i_free_below,
    output logic                   o_free_below,
    output logic                   o_grant
);
    import lfca_pkg::*;

    logic                 r_busy;
    logic                 n_busy;
    logic [TIME_BITS-1:0] r_rel;
    logic                 w_due;

    assign w_due        = r_busy && (r_rel <= i_now);
    assign o_free_below = i_free_below | ~r_busy;
    assign o_grant      = i_ctl.alloc_en && !r_busy && !i_free_below;

    always_comb begin
        n_busy = r_busy;
        if (i_ctl.rel_en && w_due) begin
            n_busy = 1'b0;
        end else if (o_grant) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grant) begin
            r_rel <= i_leave;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lowest_free_chair_allocator.sv
// flow: accepting an input beat runs the release pass through the chain of chair
//   cells, then S_ALLOC runs the allocate pass and registers the result beat; new
//   arrivals are refused in S_ALLOC; a waiting result stalls the allocate pass
// reset: synchronous active-low i_rst_n frees every chair, empties the result
//   register and clears r_target to zero
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_chair_allocator #(
    parameter int NUM_CHAIRS = 64,
    parameter int TIME_BITS  = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [lfca_pkg::ID_W-1:0]        i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [lfca_pkg::ID_W-1:0]        i_friend_id,
    input  wire  [lfca_pkg::IN_TIME_W-1:0]   i_arrive_time,
    input  wire  [lfca_pkg::IN_TIME_W-1:0]   i_leave_time,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [lfca_pkg::CHAIR_W-1:0]     o_chair,
    output logic                             o_is_target,
    output logic                             o_full_res
);
    import lfca_pkg::*;

    localparam int CW = $clog2(NUM_CHAIRS);
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_ALLOC = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [ID_W-1:0]      r_target;
    logic [TIME_BITS-1:0] r_leave;
    logic                 r_is_tgt;
    logic                 r_out_valid;

    logic                 w_in_acc;
    logic                 w_alloc_go;
    logic [63:0]          w_now_ext;
    logic [63:0]          w_leave_ext;
    logic [TIME_BITS-1:0] w_now;
    t_cell_ctl            w_ctl;
    logic [NUM_CHAIRS:0]  w_free_chain;
    logic [NUM_CHAIRS-1:0] w_grant;
    logic [CW-1:0]        w_idx;
    logic [15:0]          w_idx_ext;
    logic                 w_full;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_alloc_go  = (r_state == S_ALLOC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign w_now_ext   = {32'b0, i_arrive_time};
    assign w_leave_ext = {32'b0, i_leave_time};
    assign w_now       = w_now_ext[TIME_BITS-1:0];

    assign w_ctl.rel_en   = w_in_acc;
    assign w_ctl.alloc_en = w_alloc_go;

    assign w_free_chain[0] = 1'b0;

    for (genvar g = 0; g < NUM_CHAIRS; g++) begin : g_cell
        lfca_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_now       (w_now),
            .i_leave     (r_leave),
            .i_free_below(w_free_chain[g]),
            .o_free_below(w_free_chain[g+1]),
            .o_grant     (w_grant[g])
        );
    end

    assign w_full = !w_free_chain[NUM_CHAIRS];

    always_comb begin
        w_idx = '0;
        for (int c = 0; c < NUM_CHAIRS; c++) begin
            if (w_grant[c]) begin
                w_idx = w_idx | CW'(c);
            end
        end
    end

    assign w_idx_ext = 16'(w_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (w_alloc_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= '0;
        end else begin
            r_state <= n_state;
            if (w_alloc_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
        end
    end

    // beat payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_leave  <= w_leave_ext[TIME_BITS-1:0];
            r_is_tgt <= (i_friend_id == r_target);
        end
        if (w_alloc_go) begin
            o_chair     <= w_idx_ext[CHAIR_W-1:0];
            o_is_target <= r_is_tgt;
            o_full_res  <= w_full;
        end
    end

    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one chair granted");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc_go |-> (w_full == (w_grant == '0)))
        else $error("full flag disagrees with grant");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc_go |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("allocate pass did not produce a result beat");

    a_no_idle_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_grant != '0) |-> (r_state == S_ALLOC))
        else $error("chair granted outside allocate pass");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lfca_pkg::*;

    localparam int SEATS    = 64;
    localparam int T_BITS   = 32;
    localparam int N_PHASES = 8;

    typedef struct packed {
        logic [ID_W-1:0]      fid;
        logic [IN_TIME_W-1:0] arrive;
        logic [IN_TIME_W-1:0] leave;
    } arrival_t;

    typedef struct packed {
        logic [CHAIR_W-1:0] chair;
        logic               is_target;
        logic               full;
    } seat_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [ID_W-1:0]      i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ID_W-1:0]      i_friend_id = '0;
    logic [IN_TIME_W-1:0] i_arrive_time = '0;
    logic [IN_TIME_W-1:0] i_leave_time = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CHAIR_W-1:0]   o_chair;
    logic                 o_is_target;
    logic                 o_full_res;

    lowest_free_chair_allocator #(
        .NUM_CHAIRS(SEATS),
        .TIME_BITS (T_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_friend_id  (i_friend_id),
        .i_arrive_time(i_arrive_time),
        .i_leave_time (i_leave_time),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_chair      (o_chair),
        .o_is_target  (o_is_target),
        .o_full_res   (o_full_res)
    );

    // chair occupancy mirror
    logic                 chair_busy [SEATS];
    logic [IN_TIME_W-1:0] chair_release [SEATS];
    logic [ID_W-1:0]      target_id;

    arrival_t pending_arrivals [$];
    seat_t    seats_due [$];

    int  arrivals_queued = 0;
    int  seats_checked   = 0;
    int  errors          = 0;
    int  n_full          = 0;
    int  n_target        = 0;
    int  n_settings      = 0;
    int  top_chair       = 0;
    int  gap_left        = 0;
    int  stall_left      = 0;
    bit  idle_mode       = 1'b0;
    logic in_acc         = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic seat_t seat_arrival(arrival_t a);
        seat_t s;
        int    pick;
        pick = -1;
        for (int c = 0; c < SEATS; c++) begin
            if (chair_busy[c] && chair_release[c] <= a.arrive)
                chair_busy[c] = 1'b0;
        end
        for (int c = 0; c < SEATS; c++) begin
            if (!chair_busy[c] && pick < 0)
                pick = c;
        end
        s.is_target = (a.fid == target_id);
        if (pick >= 0) begin
            chair_busy[pick]    = 1'b1;
            chair_release[pick] = a.leave;
            s.chair             = pick[CHAIR_W-1:0];
            s.full              = 1'b0;
        end else begin
            s.chair = '0;
            s.full  = 1'b1;
        end
        return s;
    endfunction

    // sender
    always @(negedge i_clk) begin
        arrival_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_acc) begin
            // beat still waiting
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (pending_arrivals.size() != 0) begin
            nxt           = pending_arrivals.pop_front();
            i_friend_id   <= nxt.fid;
            i_arrive_time <= nxt.arrive;
            i_leave_time  <= nxt.leave;
            i_in_valid    <= 1'b1;
            gap_left      <= idle_mode ? pick_gap() : 0;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_mode && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap() + 1;
        end
    end

    // prediction and result check
    always @(posedge i_clk) begin
        arrival_t a;
        seat_t    want;
        in_acc <= i_rst_n && i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            for (int c = 0; c < SEATS; c++) begin
                chair_busy[c]    = 1'b0;
                chair_release[c] = '0;
            end
            target_id = '0;
        end else begin
            if (i_cfg_we)
                target_id = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                a.fid    = i_friend_id;
                a.arrive = i_arrive_time;
                a.leave  = i_leave_time;
                seats_due.push_back(seat_arrival(a));
            end
            if (o_out_valid && i_out_ready) begin
                if (seats_due.size() == 0) begin
                    $error("result beat with no arrival waiting: chair %0d", o_chair);
                    errors++;
                end else begin
                    want = seats_due.pop_front();
                    seats_checked++;
                    if (o_chair !== want.chair) begin
                        $error("chair: expected %0d, got %0d", want.chair, o_chair);
                        errors++;
                    end
                    if (o_is_target !== want.is_target) begin
                        $error("is_target: expected %0b, got %0b", want.is_target,
                               o_is_target);
                        errors++;
                    end
                    if (o_full_res !== want.full) begin
                        $error("full_res: expected %0b, got %0b", want.full, o_full_res);
                        errors++;
                    end
                    if (want.full)
                        n_full++;
                    if (want.is_target)
                        n_target++;
                    if (!want.full && int'(want.chair) > top_chair)
                        top_chair = want.chair;
                end
            end
        end
    end

    task automatic push_arrival(input logic [ID_W-1:0] fid,
                                input logic [IN_TIME_W-1:0] arrive,
                                input logic [IN_TIME_W-1:0] leave);
        arrival_t a;
        a.fid    = fid;
        a.arrive = arrive;
        a.leave  = leave;
        pending_arrivals.push_back(a);
        arrivals_queued++;
    endtask

    task automatic write_target(input logic [ID_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (seats_checked != arrivals_queued)
            @(negedge i_clk);
    endtask

    // kind 0: dense arrivals that fill every chair, kind 1: sparse,
    // kind 2: medium load mixed with unordered noise beats
    task automatic queue_phase(input int kind, input int count,
                               input logic [ID_W-1:0] tgt);
        logic [IN_TIME_W-1:0] t_now;
        logic [ID_W-1:0]      fid;
        int max_step, min_hold, max_hold, r;
        case (kind)
            0: begin max_step = 2;  min_hold = 30; max_hold = 300; end
            1: begin max_step = 20; min_hold = 0;  max_hold = 150; end
            default: begin max_step = 4; min_hold = 0; max_hold = 250; end
        endcase
        if ($urandom_range(0, 3) == 0)
            t_now = 32'hFFFF_F000 + $urandom_range(0, 4095);
        else
            t_now = $urandom;
        // arrival at the latest time frees every chair
        push_arrival(tgt, '1, '0);
        for (int i = 1; i < count; i++) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                fid = tgt;
            else if (r == 1)
                fid = '0;
            else if (r == 2)
                fid = '1;
            else
                fid = $urandom;
            if (kind == 2 && $urandom_range(0, 7) == 0) begin
                push_arrival(fid, $urandom, $urandom);
            end else begin
                t_now = t_now + $urandom_range(0, max_step);
                push_arrival(fid, t_now, t_now + $urandom_range(min_hold, max_hold));
            end
        end
    endtask

    initial begin
        logic [ID_W-1:0] tgt;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_target('1);
        push_arrival('0, 32'd0, 32'd0);
        push_arrival('1, 32'd0, '1);
        push_arrival(16'h1234, 32'd5, 32'd2);
        push_arrival(16'h0001, 32'd5, 32'd7);
        push_arrival(16'hFFFE, 32'd7, 32'd7);
        push_arrival('1, 32'd7, 32'd100);
        push_arrival(16'h8000, '1, '0);
        push_arrival(16'h7FFF, 32'd3, 32'd10);
        push_arrival(16'h5555, 32'd0, 32'd1);
        push_arrival(16'hAAAA, 32'h8000_0000, 32'h7FFF_FFFF);
        push_arrival('1, 32'hAAAA_AAAA, 32'h5555_5555);
        push_arrival('0, 32'h5555_5555, 32'hAAAA_AAAA);
        push_arrival(16'h00FF, '1, '1);
        push_arrival(16'hFF00, '1, '0);
        push_arrival('1, 32'd0, '1);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0, 5: tgt = '0;
                3:    tgt = '1;
                default: tgt = $urandom;
            endcase
            idle_mode = (p % 4 != 1);
            write_target(tgt);
            queue_phase(p % 3, 215, tgt);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (seats_due.size() != 0) begin
            $error("%0d expected results never arrived", seats_due.size());
            errors++;
        end
        $display("covered %0d arrivals under %0d target settings", seats_checked, n_settings);
        $display("full results %0d, target hits %0d, highest chair %0d",
                 n_full, n_target, top_chair);
        if (errors == 0)
            $display("lowest_free_chair_allocator regression: pass");
        else
            $display("lowest_free_chair_allocator regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("lowest_free_chair_allocator regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lfca_pkg.sv
hdl/lfca_cell.sv
hdl/lowest_free_chair_allocator.sv
dv/testbench.sv
